// ===== rtl/u2da_pkg.sv =====
// Package for the unsigned binary to decimal ASCII converter.
// Holds shared constants, the front-end state type and the digit-count helper.
// No dependencies.
`default_nettype none

package u2da_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned QueueDepth    = 2;

  // Upper two bits of an ASCII digit: '0' is 6'b11_0000.
  localparam logic [1:0] AsciiDigitHi = 2'b11;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } front_state_e;

  // Decimal digits needed for any width-bit unsigned value
  // (floor(w * log10(2)) + 1, exact up to 64 bits).
  function automatic int unsigned num_digits(input int unsigned w);
    return (w * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/unsigned_to_decimal_ascii.sv =====
// Top level of the unsigned binary to decimal ASCII converter.
// Instantiates u2da_front, u2da_queue and u2da_back; uses u2da_pkg.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------
//   input    | push / full        | value_i [VALUE_WIDTH]
//   result   | empty / pop        | digit_char_o [6], last_digit_o
//
// The front end accepts a value, runs the shift-add-3 loop once per input bit,
// then pushes the result to the queue once it has room; full is high during the loop and push.
// The back end takes a word from the queue, then steps through each decimal digit
// position (NUM_DIGITS, 10 at 32 bits), skipping leading zeros.
// A stalled result port backs up through the two-entry queue into the front end.
// Reset clears all control state; no clearing pass is needed.
`default_nettype none

module unsigned_to_decimal_ascii
  import u2da_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [5:0]                  digit_char_o,
  output logic                        last_digit_o
);

  localparam int unsigned NumDigits = num_digits(VALUE_WIDTH);
  localparam int unsigned BcdW      = 4 * NumDigits;

  logic            q_push, q_full, q_pop, q_empty;
  logic [BcdW-1:0] q_wdata, q_rdata;

  u2da_front #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_DIGITS (NumDigits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .value_i (value_i),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_data_o(q_wdata)
  );

  u2da_queue #(
    .DATA_W(BcdW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  u2da_back #(
    .NUM_DIGITS(NumDigits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

endmodule

`default_nettype wire

// ===== rtl/u2da_front.sv =====
// Front end: accepts one value and runs the bit-serial shift-add-3 conversion.
// Pushes the finished packed BCD word into the queue. Uses u2da_pkg.
`default_nettype none

module u2da_front
  import u2da_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef,
  parameter int unsigned NUM_DIGITS  = num_digits(ValueWidthDef)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [VALUE_WIDTH-1:0]    value_i,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output logic [4*NUM_DIGITS-1:0]        q_data_o
);

  localparam int unsigned CntW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [CntW-1:0] LastBit = CntW'(VALUE_WIDTH - 1);

  front_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0]  sh_q, sh_d;
  logic [4*NUM_DIGITS-1:0] bcd_q, bcd_d;
  logic [4*NUM_DIGITS-1:0] bcd_adj;
  logic [CntW-1:0]         cnt_q, cnt_d;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < int'(NUM_DIGITS); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE: begin
        if (push) state_d = FE_CONV;
      end
      FE_CONV: begin
        if (cnt_q == LastBit) state_d = FE_PUSH;
      end
      FE_PUSH: begin
        if (!q_full_i) state_d = FE_IDLE;
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    sh_d     = sh_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    full     = 1'b1;
    q_push_o = 1'b0;
    case (state_q)
      FE_IDLE: begin
        full = 1'b0;
        if (push) begin
          sh_d  = value_i;
          bcd_d = '0;
          cnt_d = '0;
        end
      end
      FE_CONV: begin
        bcd_d = {bcd_adj[4*NUM_DIGITS-2:0], sh_q[VALUE_WIDTH-1]};
        sh_d  = sh_q << 1;
        cnt_d = cnt_q + CntW'(1);
      end
      FE_PUSH: begin
        q_push_o = !q_full_i;
      end
      default: begin
        full = 1'b1;
      end
    endcase
  end

  assign q_data_o = bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

endmodule

`default_nettype wire

// ===== rtl/u2da_queue.sv =====
// Short queue of packed BCD words between front end and back end.
// Uses u2da_pkg for its depth.
`default_nettype none

module u2da_queue
  import u2da_pkg::*;
#(
  parameter int unsigned DATA_W = 4 * num_digits(ValueWidthDef)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic [DATA_W-1:0]      data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      count_q <= count_q + (PtrW+1)'(1);
      else if (do_pop && !do_push) count_q <= count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/u2da_back.sv =====
// Back end: takes a BCD word from the queue, skips leading zeros and emits one
// ASCII digit per cycle into the output register when free. Uses u2da_pkg.
`default_nettype none

module u2da_back
  import u2da_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = num_digits(ValueWidthDef)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_empty_i,
  input  wire logic [4*NUM_DIGITS-1:0] q_data_i,
  output logic                         q_pop_o,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [5:0]                   digit_char_o,
  output logic                         last_digit_o
);

  localparam int unsigned RemW = $clog2(NUM_DIGITS + 1);
  localparam logic [RemW-1:0] RemOne = RemW'(1);

  logic                    busy_q, busy_d;
  logic                    started_q, started_d;
  logic [4*NUM_DIGITS-1:0] bcd_q, bcd_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic                    out_vld_q, out_vld_d;
  logic [5:0]              char_q, char_d;
  logic                    last_q, last_d;

  logic [3:0] top_digit;
  logic       emit, slot_free;

  assign top_digit = bcd_q[4*NUM_DIGITS-1 -: 4];
  // A digit goes out once a nonzero digit was seen; the final digit always does.
  assign emit      = started_q || (top_digit != 4'd0) || (rem_q == RemOne);
  assign slot_free = !out_vld_q || pop;
  assign q_pop_o   = !busy_q && !q_empty_i;

  always_comb begin
    busy_d    = busy_q;
    started_d = started_q;
    bcd_d     = bcd_q;
    rem_d     = rem_q;
    out_vld_d = out_vld_q && !pop;
    char_d    = char_q;
    last_d    = last_q;
    if (!busy_q) begin
      if (!q_empty_i) begin
        busy_d    = 1'b1;
        started_d = 1'b0;
        bcd_d     = q_data_i;
        rem_d     = RemW'(NUM_DIGITS);
      end
    end else if (!emit || slot_free) begin
      bcd_d = bcd_q << 4;
      rem_d = rem_q - RemOne;
      if (rem_q == RemOne) busy_d = 1'b0;
      if (emit) begin
        started_d = 1'b1;
        out_vld_d = 1'b1;
        char_d    = {AsciiDigitHi, top_digit};
        last_d    = (rem_q == RemOne);
      end
    end
  end

  assign empty        = !out_vld_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      started_q <= 1'b0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      started_q <= started_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

`default_nettype wire
